FILE: hdl/mrns_pkg.sv
// mrns_pkg: shared types and constants of the midi receiver note stack
// used by mrns_ctrl, mrns_dp and midi_receiver_note_stack
package mrns_pkg;

    // midi status codes
    localparam logic [7:0] SYS_FIRST   = 8'hF0;
    localparam logic [7:0] STS_NOTE_OFF = 8'h80;
    localparam logic [7:0] STS_NOTE_ON  = 8'h90;
    localparam logic [7:0] STS_CTRL_CHG = 8'hB0;
    localparam logic [7:0] STS_BEND     = 8'hE0;

    localparam logic [4:0] BEND_RANGE_MAX = 5'd24;
    localparam logic [4:0] BEND_RANGE_RST = 5'd6;
    localparam logic [6:0] INIT_NOTE      = 7'd54;

    typedef enum logic [2:0] {
        KIND_GATE_ON  = 3'd0,
        KIND_GATE_OFF = 3'd1,
        KIND_STACK    = 3'd2,
        KIND_BEND     = 3'd3,
        KIND_CC       = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        MSG_NONE,
        MSG_NOTE_ON,
        MSG_NOTE_OFF,
        MSG_CC,
        MSG_BEND
    } t_msg;

    // commands from controller to datapath
    typedef struct packed {
        logic  load;        // capture accepted byte
        logic  parse;       // update running status, compute bend product
        logic  push;
        logic  clear;
        logic  pop;
        logic  scan_start;
        logic  scan_next;
        logic  remove;
        logic  emit;        // load output register
        t_kind kind;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        t_msg msg;          // completed message, valid while decoding
        logic full;
        logic lt2;
        logic note_is_cur;
        logic scan_hit;
        logic scan_last;
    } t_sts;

endpackage

FILE: hdl/mrns_ctrl.sv
// mrns_ctrl: sequencing state machine of the midi receiver note stack
// depends on mrns_pkg; drives the mrns_dp datapath through t_cmd
module mrns_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rx_valid,
    output logic           o_rx_stall,
    output logic           o_ev_valid,
    input  logic           i_ev_stall,
    input  mrns_pkg::t_sts i_sts,
    output mrns_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    t_state          r_state, n_state;
    mrns_pkg::t_kind r_kind, n_kind;
    logic            r_ev_valid, n_ev_valid;
    logic            rx_xfer;

    assign o_rx_stall = (r_state != ST_IDLE);
    assign rx_xfer    = i_rx_valid && !o_rx_stall;
    assign o_ev_valid = r_ev_valid;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        o_cmd.kind = r_kind;
        case (r_state)
            ST_IDLE: begin
                if (rx_xfer) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                o_cmd.parse = 1'b1;
                n_state     = ST_IDLE;
                case (i_sts.msg)
                    mrns_pkg::MSG_NOTE_ON: begin
                        if (!i_sts.full) begin
                            o_cmd.push = 1'b1;
                            n_kind     = mrns_pkg::KIND_GATE_ON;
                            n_state    = ST_EMIT;
                        end
                    end
                    mrns_pkg::MSG_NOTE_OFF: begin
                        if (i_sts.lt2) begin
                            o_cmd.clear = 1'b1;
                            n_kind      = mrns_pkg::KIND_GATE_OFF;
                            n_state     = ST_EMIT;
                        end else if (i_sts.note_is_cur) begin
                            o_cmd.pop = 1'b1;
                            n_kind    = mrns_pkg::KIND_GATE_ON;
                            n_state   = ST_EMIT;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = ST_SCAN;
                        end
                    end
                    mrns_pkg::MSG_CC: begin
                        n_kind  = mrns_pkg::KIND_CC;
                        n_state = ST_EMIT;
                    end
                    mrns_pkg::MSG_BEND: begin
                        n_kind  = mrns_pkg::KIND_BEND;
                        n_state = ST_EMIT;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN: begin
                if (i_sts.scan_hit) begin
                    o_cmd.remove = 1'b1;
                    n_kind       = mrns_pkg::KIND_STACK;
                    n_state      = ST_EMIT;
                end else if (i_sts.scan_last) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            ST_EMIT: begin
                if (!r_ev_valid || !i_ev_stall) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_ev_valid = o_cmd.emit || (r_ev_valid && i_ev_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_kind     <= mrns_pkg::KIND_GATE_ON;
            r_ev_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_kind     <= n_kind;
            r_ev_valid <= n_ev_valid;
        end
    end

    // an accepted byte is always decoded in the next cycle
    a_xfer_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_xfer |=> (r_state == ST_DECODE))
        else $error("accepted byte not decoded");

    // the output register is only overwritten once its result has left
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (!r_ev_valid || !i_ev_stall))
        else $error("result overwritten while stalled");

    // a search for a held note only runs with two or more notes held
    a_scan_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !i_sts.lt2)
        else $error("note search with fewer than two notes");

endmodule

FILE: hdl/mrns_dp.sv
// mrns_dp: running status parser, note stack, bend multiplier and output register
// depends on mrns_pkg; controlled by mrns_ctrl through t_cmd
module mrns_dp #(
    parameter int STACK_DEPTH = 16,
    parameter int CW          = $clog2(STACK_DEPTH + 1),
    parameter int IW          = $clog2(STACK_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mrns_pkg::t_cmd     i_cmd,
    output mrns_pkg::t_sts     o_sts,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_data,
    output logic [2:0]         o_event_kind,
    output logic [6:0]         o_sounding_note,
    output logic [CW-1:0]      o_held_notes,
    output logic signed [18:0] o_bend_offset,
    output logic [6:0]         o_cc_number,
    output logic [6:0]         o_cc_value
);

    logic [7:0]          r_byte;
    logic [7:0]          r_status;
    logic [6:0]          r_first;
    logic                r_await;
    logic [6:0]          r_stack [STACK_DEPTH];
    logic [CW-1:0]       r_count;
    logic [6:0]          r_current;
    logic [IW-1:0]       r_idx;
    logic [4:0]          r_bend_range;
    logic signed [18:0]  r_bend;

    logic                is_sys, is_status, msg_done;
    logic signed [13:0]  bend_val;
    logic signed [5:0]   bend_rng;
    logic signed [19:0]  bend_prod;
    logic [IW-1:0]       pop_addr;

    assign is_sys    = (r_byte >= mrns_pkg::SYS_FIRST);
    assign is_status = r_byte[7];
    assign msg_done  = !is_status && r_await;

    // value - 8192 is the 14-bit word with its top bit flipped
    assign bend_val  = $signed({~r_byte[6], r_byte[5:0], r_first});
    assign bend_rng  = $signed({1'b0, r_bend_range});
    assign bend_prod = bend_val * bend_rng;
    assign pop_addr  = IW'(r_count - CW'(2));

    always_comb begin
        o_sts = '0;
        o_sts.msg = mrns_pkg::MSG_NONE;
        if (msg_done) begin
            if (r_status == mrns_pkg::STS_NOTE_ON && r_byte != 8'd0) begin
                o_sts.msg = mrns_pkg::MSG_NOTE_ON;
            end else if (r_status == mrns_pkg::STS_NOTE_ON
                         || r_status == mrns_pkg::STS_NOTE_OFF) begin
                o_sts.msg = mrns_pkg::MSG_NOTE_OFF;
            end else if (r_status == mrns_pkg::STS_CTRL_CHG) begin
                o_sts.msg = mrns_pkg::MSG_CC;
            end else if (r_status == mrns_pkg::STS_BEND) begin
                o_sts.msg = mrns_pkg::MSG_BEND;
            end
        end
        o_sts.full        = (r_count >= CW'(STACK_DEPTH));
        o_sts.lt2         = (r_count < CW'(2));
        o_sts.note_is_cur = (r_first == r_current);
        o_sts.scan_hit    = (r_stack[r_idx] == r_first);
        o_sts.scan_last   = (CW'(r_idx) == (r_count - CW'(1)));
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status     <= 8'd0;
            r_first      <= 7'd0;
            r_await      <= 1'b0;
            r_count      <= '0;
            r_current    <= mrns_pkg::INIT_NOTE;
            r_bend_range <= mrns_pkg::BEND_RANGE_RST;
        end else begin
            if (i_cfg_we) begin
                r_bend_range <= (i_cfg_data > mrns_pkg::BEND_RANGE_MAX)
                                ? mrns_pkg::BEND_RANGE_MAX : i_cfg_data;
            end
            if (i_cmd.parse && !is_sys) begin
                if (is_status) begin
                    r_status <= r_byte;
                    r_await  <= 1'b0;
                end else if (!r_await) begin
                    r_first <= r_byte[6:0];
                    r_await <= 1'b1;
                end else begin
                    r_await <= 1'b0;
                end
            end
            if (i_cmd.push) begin
                r_count   <= r_count + CW'(1);
                r_current <= r_first;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
            end
            if (i_cmd.pop) begin
                r_count   <= r_count - CW'(1);
                r_current <= r_stack[pop_addr];
            end
            if (i_cmd.remove) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // payload: stack entries above the count are never read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_rx_byte;
        end
        if (i_cmd.parse) begin
            r_bend <= bend_prod[18:0];
        end
        if (i_cmd.scan_start) begin
            r_idx <= '0;
        end else if (i_cmd.scan_next) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.push) begin
            r_stack[r_count[IW-1:0]] <= r_first;
        end
        if (i_cmd.remove) begin
            for (int j = 0; j < STACK_DEPTH - 1; j++) begin
                if (IW'(j) >= r_idx && CW'(j + 1) < r_count) begin
                    r_stack[j] <= r_stack[j + 1];
                end
            end
        end
        if (i_cmd.emit) begin
            o_event_kind    <= i_cmd.kind;
            o_sounding_note <= r_current;
            o_held_notes    <= r_count;
            o_bend_offset   <= (i_cmd.kind == mrns_pkg::KIND_BEND) ? r_bend : '0;
            o_cc_number     <= (i_cmd.kind == mrns_pkg::KIND_CC) ? r_first : 7'd0;
            o_cc_value      <= (i_cmd.kind == mrns_pkg::KIND_CC) ? r_byte[6:0] : 7'd0;
        end
    end

endmodule

FILE: hdl/midi_receiver_note_stack.sv
// midi_receiver_note_stack: midi byte receiver with last-note-priority note stack
// depends on mrns_pkg, mrns_ctrl and mrns_dp
//
// usage
// - rx channel: one midi byte per transfer (i_rx_valid / o_rx_stall, i_rx_byte)
// - event channel: at most one event per byte (o_ev_valid / i_ev_stall) with
//   kind, sounding note, held note count, bend offset and controller fields
// - config: i_cfg_we writes the bend range, values above 24 are stored as 24;
//   write only while no byte is in flight
// - a byte is taken only in the idle state; a byte without an event frees the
//   input after the decode state, a byte with an event after the emit state,
//   and a release of a note that is not held after a search of the held stack
// - o_ev_valid rises once the emit state has loaded the output register, which
//   waits while an earlier event is stalled; removal of a held note that is not
//   sounding first walks the stack one entry per cycle in the search state
// - the output register parts the two sides: the next byte is taken while an
//   event waits; a byte that yields another event waits until the held one
//   has been transferred
// - reset: running status clears, stack empties, sounding note is 54,
//   bend range is 6; no clearing pass is needed
module midi_receiver_note_stack #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // byte input
    input  logic                                  i_rx_valid,
    output logic                                  o_rx_stall,
    input  logic [7:0]                            i_rx_byte,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [4:0]                            i_cfg_data,
    // event output
    output logic                                  o_ev_valid,
    input  logic                                  i_ev_stall,
    output logic [2:0]                            o_event_kind,
    output logic [6:0]                            o_sounding_note,
    output logic [$clog2(STACK_DEPTH + 1)-1:0]    o_held_notes,
    output logic signed [18:0]                    o_bend_offset,
    output logic [6:0]                            o_cc_number,
    output logic [6:0]                            o_cc_value
);

    // command and status between sequencer and datapath
    mrns_pkg::t_cmd cmd;
    mrns_pkg::t_sts sts;

    // sequencer: idle, decode, note search, event hand-off
    mrns_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_stall (o_rx_stall),
        .o_ev_valid (o_ev_valid),
        .i_ev_stall (i_ev_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: parser, stack, bend product, output register
    mrns_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_rx_byte       (i_rx_byte),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_event_kind    (o_event_kind),
        .o_sounding_note (o_sounding_note),
        .o_held_notes    (o_held_notes),
        .o_bend_offset   (o_bend_offset),
        .o_cc_number     (o_cc_number),
        .o_cc_value      (o_cc_value)
    );

endmodule

FILE: verif/midi_receiver_note_stack_tb.sv
// midi_receiver_note_stack_tb: self-checking bench for the midi receiver note stack
// depends on mrns_pkg and midi_receiver_note_stack; directed and random byte streams
// are checked event by event against a note stack predictor kept in this file
module midi_receiver_note_stack_tb;

    localparam int STACK_DEPTH  = 16;
    localparam int BEND_CENTER  = 8192;
    localparam int DRAIN_CYCLES = STACK_DEPTH + 8;   // longest search plus margin
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 100;

    // one event as it leaves the block
    typedef struct {
        mrns_pkg::t_kind    kind;
        logic [6:0]         note;
        logic [4:0]         held;
        logic signed [18:0] bend;
        logic [6:0]         ccn;
        logic [6:0]         ccv;
    } t_midi_event;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_rx_valid = 1'b0;
    logic [7:0]  i_rx_byte  = 8'h00;
    logic        i_cfg_we   = 1'b0;
    logic [4:0]  i_cfg_data = 5'd0;
    logic        i_ev_stall = 1'b0;
    logic        o_rx_stall;
    logic        o_ev_valid;
    logic [2:0]  o_event_kind;
    logic [6:0]  o_sounding_note;
    logic [4:0]  o_held_notes;
    logic signed [18:0] o_bend_offset;
    logic [6:0]  o_cc_number;
    logic [6:0]  o_cc_value;

    // bench bookkeeping
    logic [7:0]  byte_pending [$];
    t_midi_event event_expected [$];
    int          bytes_queued  = 0;
    int          bytes_taken   = 0;
    int          mismatch_count = 0;
    int          cycle_count   = 0;
    logic        rx_taken = 1'b0;
    logic        ev_taken = 1'b0;
    int          rx_gap = 0;
    int          ev_hold = 0;
    bit          rx_calm = 1'b0;
    bit          ev_calm = 1'b0;

    // predictor state: running status, pairing and the note stack
    logic [7:0]  rs_status  = 8'h00;
    logic [6:0]  rs_first   = 7'd0;
    bit          rs_await   = 1'b0;
    logic [6:0]  held_stack [STACK_DEPTH];
    int          held_count = 0;
    logic [6:0]  cur_note   = mrns_pkg::INIT_NOTE;
    logic [4:0]  bend_range_q = mrns_pkg::BEND_RANGE_RST;

    midi_receiver_note_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .o_rx_stall     (o_rx_stall),
        .i_rx_byte      (i_rx_byte),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_ev_valid     (o_ev_valid),
        .i_ev_stall     (i_ev_stall),
        .o_event_kind   (o_event_kind),
        .o_sounding_note(o_sounding_note),
        .o_held_notes   (o_held_notes),
        .o_bend_offset  (o_bend_offset),
        .o_cc_number    (o_cc_number),
        .o_cc_value     (o_cc_value)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [18:0] got, want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    // idle draw per item; calm stretches run with no idling at all
    function automatic int draw_wait(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 6));
    endfunction

    function automatic void add_event(input mrns_pkg::t_kind kind, input logic [18:0] bend,
                                      input logic [6:0] ccn, input logic [6:0] ccv);
        t_midi_event ev;
        ev.kind = kind;
        ev.note = cur_note;
        ev.held = held_count[4:0];
        ev.bend = bend;
        ev.ccn  = ccn;
        ev.ccv  = ccv;
        event_expected.push_back(ev);
    endfunction

    // last-note-priority release: pop, remove from inside, or gate off
    function automatic void release_note(input logic [6:0] note);
        int idx;
        if (held_count < 2) begin
            // one or no note held: gate drops, stack empties, note kept
            foreach (held_stack[i]) held_stack[i] = 7'd0;
            held_count = 0;
            add_event(mrns_pkg::KIND_GATE_OFF, '0, '0, '0);
            return;
        end
        if (note == cur_note) begin
            // sounding note released: fall back to the one below
            held_count--;
            held_stack[held_count] = 7'd0;
            cur_note = held_stack[held_count - 1];
            add_event(mrns_pkg::KIND_GATE_ON, '0, '0, '0);
            return;
        end
        idx = -1;
        for (int i = 0; i < held_count; i++) begin
            if (idx < 0 && held_stack[i] == note) idx = i;
        end
        if (idx < 0) return;   // not held: nothing happens
        for (int i = idx; i + 1 < held_count; i++) held_stack[i] = held_stack[i + 1];
        held_count--;
        held_stack[held_count] = 7'd0;
        add_event(mrns_pkg::KIND_STACK, '0, '0, '0);
    endfunction

    // one accepted byte through running status and message decode
    function automatic void predict_byte(input logic [7:0] b);
        logic [6:0] d1;
        logic [6:0] d2;
        int         bend_val;
        if (b >= mrns_pkg::SYS_FIRST) return;   // system bytes are dropped
        if (b[7]) begin
            rs_status = b;
            rs_await  = 1'b0;
            return;
        end
        if (!rs_await) begin
            rs_first = b[6:0];
            rs_await = 1'b1;
            return;
        end
        rs_await = 1'b0;
        d1 = rs_first;
        d2 = b[6:0];
        if (rs_status == mrns_pkg::STS_NOTE_ON && d2 != 7'd0) begin
            if (held_count < STACK_DEPTH) begin
                held_stack[held_count] = d1;
                held_count++;
                cur_note = d1;
                add_event(mrns_pkg::KIND_GATE_ON, '0, '0, '0);
            end
        end else if (rs_status == mrns_pkg::STS_NOTE_ON
                     || rs_status == mrns_pkg::STS_NOTE_OFF) begin
            release_note(d1);
        end else if (rs_status == mrns_pkg::STS_CTRL_CHG) begin
            add_event(mrns_pkg::KIND_CC, '0, d1, d2);
        end else if (rs_status == mrns_pkg::STS_BEND) begin
            bend_val = (int'({d2, d1}) - BEND_CENTER) * int'(bend_range_q);
            add_event(mrns_pkg::KIND_BEND, bend_val[18:0], '0, '0);
        end
    endfunction

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // monitor: checks event transfers, feeds accepted bytes to the predictor
    always @(posedge i_clk) begin
        t_midi_event want;
        if (!i_rst_n) begin
            rx_taken <= 1'b0;
            ev_taken <= 1'b0;
        end else begin
            rx_taken <= i_rx_valid && !o_rx_stall;
            ev_taken <= o_ev_valid && !i_ev_stall;
            if (o_ev_valid && !i_ev_stall) begin
                if (event_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected event kind %0d", o_event_kind));
                end else begin
                    want = event_expected.pop_front();
                    check_field("event_kind", 19'(o_event_kind), 19'(want.kind));
                    check_field("sounding_note", 19'(o_sounding_note), 19'(want.note));
                    check_field("held_notes", 19'(o_held_notes), 19'(want.held));
                    check_field("bend_offset", o_bend_offset, want.bend);
                    check_field("cc_number", 19'(o_cc_number), 19'(want.ccn));
                    check_field("cc_value", 19'(o_cc_value), 19'(want.ccv));
                end
            end
            if (i_rx_valid && !o_rx_stall) begin
                predict_byte(i_rx_byte);
                bytes_taken <= bytes_taken + 1;
            end
        end
    end

    // byte driver: one byte per transfer, random gap after each
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
        end else if (!i_rx_valid || rx_taken) begin
            if (rx_gap > 0) begin
                i_rx_valid <= 1'b0;
                rx_gap--;
            end else if (byte_pending.size() > 0) begin
                i_rx_valid <= 1'b1;
                i_rx_byte  <= byte_pending.pop_front();
                if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
                rx_gap = draw_wait(rx_calm);
            end else begin
                i_rx_valid <= 1'b0;
            end
        end
    end

    // event stall: a fresh stall count after every event transfer
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ev_stall <= 1'b0;
        end else begin
            if (ev_taken) begin
                if ($urandom_range(0, 19) == 0) ev_calm = !ev_calm;
                ev_hold = draw_wait(ev_calm);
            end
            if (ev_hold > 0) begin
                i_ev_stall <= 1'b1;
                ev_hold--;
            end else begin
                i_ev_stall <= 1'b0;
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        byte_pending.push_back(b);
        bytes_queued++;
    endtask

    // status (unless running status is kept), then data bytes;
    // realtime bytes and truncation sneak in now and then
    task automatic queue_message(input logic [7:0] status, inout logic [7:0] last_status,
                                 input logic [6:0] d1, input logic [6:0] d2,
                                 inout int items);
        if (status != last_status || $urandom_range(0, 3) == 0) begin
            queue_byte(status);
            items++;
        end
        last_status = status;
        if ($urandom_range(0, 29) == 0) queue_byte(8'($urandom_range(8'hF0, 8'hFF)));
        queue_byte({1'b0, d1});
        items++;
        if ($urandom_range(0, 29) == 0) queue_byte(8'($urandom_range(8'hF0, 8'hFF)));
        if ($urandom_range(0, 15) != 0) begin
            queue_byte({1'b0, d2});
            items++;
        end else begin
            last_status = 8'h00;   // truncated message, next one restates status
        end
    endtask

    task automatic queue_random_phase(input int n_items);
        logic [6:0] note_pool [8];
        logic [7:0] last_status;
        logic [7:0] other;
        logic [6:0] note;
        int         on_weight;
        int         pick;
        int         items;
        foreach (note_pool[i]) note_pool[i] = 7'($urandom_range(0, 127));
        on_weight   = $urandom_range(2, 7);   // sets how full the stack tends to run
        last_status = 8'h00;
        items       = 0;
        while (items < n_items) begin
            pick = $urandom_range(0, 11);
            note = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                               : note_pool[$urandom_range(0, 7)];
            if (pick < on_weight) begin
                queue_message(mrns_pkg::STS_NOTE_ON, last_status, note,
                              7'($urandom_range(1, 127)), items);
            end else if (pick < 8) begin
                // release by note-off or by note-on with zero velocity
                if ($urandom_range(0, 1) == 0) begin
                    queue_message(mrns_pkg::STS_NOTE_OFF, last_status, note,
                                  7'($urandom_range(0, 127)), items);
                end else begin
                    queue_message(mrns_pkg::STS_NOTE_ON, last_status, note, 7'd0, items);
                end
            end else if (pick == 8) begin
                queue_message(mrns_pkg::STS_CTRL_CHG, last_status,
                              7'($urandom_range(0, 127)),
                              7'($urandom_range(0, 127)), items);
            end else if (pick == 9) begin
                queue_message(mrns_pkg::STS_BEND, last_status, 7'($urandom_range(0, 127)),
                              7'($urandom_range(0, 127)), items);
            end else if (pick == 10) begin
                // status the block does not act on, other channels included
                other = 8'($urandom_range(8'h80, 8'hEF));
                if (other == mrns_pkg::STS_NOTE_ON || other == mrns_pkg::STS_NOTE_OFF ||
                    other == mrns_pkg::STS_CTRL_CHG || other == mrns_pkg::STS_BEND) begin
                    other[0] = 1'b1;
                end
                queue_message(other, last_status, 7'($urandom_range(0, 127)),
                              7'($urandom_range(0, 127)), items);
            end else begin
                // lone byte of any value: stray data, lone status, system
                other = 8'($urandom_range(0, 255));
                queue_byte(other);
                if (other < mrns_pkg::SYS_FIRST) items++;
                last_status = 8'h00;
            end
        end
    endtask

    // block idle: every byte taken, every event seen, search time passed
    task automatic wait_idle();
        while (bytes_taken != bytes_queued || event_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_bend_range(input logic [4:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        bend_range_q = (value > mrns_pkg::BEND_RANGE_MAX) ? mrns_pkg::BEND_RANGE_MAX : value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [7:0] directed [$];
        logic [4:0] range_plan [7];
        foreach (held_stack[i]) held_stack[i] = 7'd0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset bend range
        directed = '{
            8'h7F, 8'h00,                  // data pair before any status
            8'h80, 8'h00, 8'h7F,           // release with nothing held
            8'h90, 8'h7F, 8'h7F,           // push top note, full velocity
            8'hF8, 8'h00, 8'h01,           // realtime byte, running status push of note 0
            8'h40, 8'h40,                  // third note
            8'h05, 8'h00,                  // release of a note never held
            8'h7F, 8'h00,                  // remove a held note from inside
            8'h40, 8'h00,                  // release sounding note, retrigger
            8'h80, 8'h33, 8'h00,           // one held: gate off whatever the note
            8'hB0, 8'h7F, 8'h7F,           // control change at the extremes
            8'hE0, 8'h00, 8'h00,           // bend full down
            8'h7F, 8'h7F                   // bend full up
        };
        foreach (directed[i]) queue_byte(directed[i]);
        wait_idle();

        // random phases, each with its own bend range; 31 checks the clamp
        range_plan = '{5'd24, 5'd0, 5'd31, 5'd1, 5'($urandom_range(0, 31)), 5'd13, 5'd6};
        foreach (range_plan[p]) begin
            write_bend_range(range_plan[p]);
            queue_random_phase(PHASE_ITEMS);
            wait_idle();
        end

        if (event_expected.size() != 0) begin
            report_mismatch($sformatf("%0d events never arrived", event_expected.size()));
        end
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
